FILE: rtl/ntst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntst_pkg: shared constants for the nested translation TLB core
// Table sizes, field widths, command and status codes.
// ----------------------------------------------------------------------------
package ntst_pkg;
  localparam int unsigned TlbEntries   = 16;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned AddrBits     = 48;
  localparam int unsigned TlbIdxW      = $clog2(TlbEntries);
  localparam int unsigned TblIdxW      = $clog2(TableEntries);
  localparam int unsigned PageW        = AddrBits - 12;

  localparam logic [1:0] CmdTranslate = 2'd0;
  localparam logic [1:0] CmdWrGuest   = 2'd1;
  localparam logic [1:0] CmdWrEpt     = 2'd2;

  localparam logic [2:0] StHit     = 3'd0;
  localparam logic [2:0] StWalkOk  = 3'd1;
  localparam logic [2:0] StGFault  = 3'd2;
  localparam logic [2:0] StEptViol = 3'd3;
  localparam logic [2:0] StWrDone  = 3'd4;

  localparam logic [2:0] CostSmall = 3'd6;
  localparam logic [2:0] CostHuge  = 3'd4;

  localparam logic CfgGuestCount = 1'b0;
  localparam logic CfgEptCount   = 1'b1;
endpackage

FILE: rtl/nested_two_stage_translation_tlb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_two_stage_translation_tlb_core
// Guest-virtual to host-physical translation with a VPID-tagged FIFO TLB.
// ----------------------------------------------------------------------------
// channel  direction  tdata fields (low bit up)
// s_axis   in         command, address, target, vpid, entry_index, huge, present
// m_axis   out        status, host_address, walk_cost, hit, miss, access totals
// cfg      in         index 0 guest_count, 1 ept_count (7 bits)
//
// One shared compare unit checks one entry per cycle: TLB slots, then guest
// table slots, then EPT slots, each read from a memory with registered data.
// A write goes to the output state, which then raises result valid. The core
// returns to idle after each result transfer. Input ready is low until the
// result has been taken. Reset clears control, counters, TLB valid and present
// bits.
module nested_two_stage_translation_tlb_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // command[1:0], address[49:2], target[97:50],
                                      // vpid[113:98], entry_index[119:114],
                                      // huge[120], present[121], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,  // status[2:0], host_address[50:3],
                                      // walk_cost[53:51], hit_total[85:54],
                                      // miss_total[117:86], access_total[149:118]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [6:0]   cfg_data_i
);
  localparam int unsigned TW  = ntst_pkg::TlbIdxW;
  localparam int unsigned XW  = ntst_pkg::TblIdxW;
  localparam int unsigned AW  = ntst_pkg::AddrBits;
  localparam int unsigned PW  = ntst_pkg::PageW;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] STlb   = 3'd1;
  localparam logic [2:0] SGuest = 3'd2;
  localparam logic [2:0] SEpt   = 3'd3;
  localparam logic [2:0] SOut   = 3'd4;

  logic [2:0]    state_q;
  logic [AW-1:0] addr_q, gpa_q;
  logic [15:0]   vpid_q;
  logic [XW:0]   idx_q;       // scan index, one wider to reach the end
  logic          rd_vld_q;    // memory read data valid for previous index
  logic [XW:0]   rd_idx_q;
  logic [6:0]    gcnt_q, ecnt_q;
  logic [TW-1:0] fifo_q;
  logic [31:0]   hit_q, miss_q, acc_q;
  logic [2:0]    st_q, cost_q;
  logic [AW-1:0] host_q;
  logic          ovld_q;

  logic [ntst_pkg::TlbEntries-1:0]   tlb_v_q;
  logic [ntst_pkg::TableEntries-1:0] g_pres_q, e_pres_q;

  // memories
  logic [15:0]   tlb_vp_m [ntst_pkg::TlbEntries];
  logic [PW-1:0] tlb_pg_m [ntst_pkg::TlbEntries];
  logic [PW-1:0] tlb_hf_m [ntst_pkg::TlbEntries];
  logic [2*AW:0] g_m [ntst_pkg::TableEntries];
  logic [2*AW-1:0] e_m [ntst_pkg::TableEntries];

  logic [15:0]   tvp_r;
  logic [PW-1:0] tpg_r, thf_r;
  logic [2*AW:0] g_r;
  logic [2*AW-1:0] e_r;

  logic [XW:0] gn, en;
  assign gn = (gcnt_q > 7'(ntst_pkg::TableEntries)) ? (XW+1)'(ntst_pkg::TableEntries)
                                                     : (XW+1)'(gcnt_q);
  assign en = (ecnt_q > 7'(ntst_pkg::TableEntries)) ? (XW+1)'(ntst_pkg::TableEntries)
                                                     : (XW+1)'(ecnt_q);

  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, acc_q, miss_q, hit_q, cost_q, host_q, st_q};

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // memory ports: one write, one read each, read data registered
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tdata[1:0] == ntst_pkg::CmdWrGuest)
      g_m[s_axis_tdata[119:114]] <= {s_axis_tdata[120], s_axis_tdata[97:50], s_axis_tdata[49:2]};
    if (in_acc && s_axis_tdata[1:0] == ntst_pkg::CmdWrEpt)
      e_m[s_axis_tdata[119:114]] <= {s_axis_tdata[97:50], s_axis_tdata[49:2]};
    g_r   <= g_m[idx_q[XW-1:0]];
    e_r   <= e_m[idx_q[XW-1:0]];
    tvp_r <= tlb_vp_m[idx_q[TW-1:0]];
    tpg_r <= tlb_pg_m[idx_q[TW-1:0]];
    thf_r <= tlb_hf_m[idx_q[TW-1:0]];
  end

  // shared comparator
  logic [AW-1:0] key;
  logic          match;
  always_comb begin
    key   = (state_q == SEpt) ? {gpa_q[AW-1:12], 12'h000} : {addr_q[AW-1:12], 12'h000};
    match = 1'b0;
    case (state_q)
      STlb:    match = tlb_v_q[rd_idx_q[TW-1:0]] && tvp_r == vpid_q
                       && tpg_r == addr_q[AW-1:12];
      SGuest:  match = g_pres_q[rd_idx_q[XW-1:0]] && g_r[AW-1:0] == key;
      SEpt:    match = e_pres_q[rd_idx_q[XW-1:0]] && e_r[AW-1:0] == key;
      default: match = 1'b0;
    endcase
  end

  logic [AW-1:0] hpa;
  assign hpa = e_r[2*AW-1:AW] | {{(AW-12){1'b0}}, gpa_q[11:0]};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= s_axis_tdata[49:2];
      vpid_q <= s_axis_tdata[113:98];
    end
    if (state_q == SEpt && rd_vld_q && match) begin
      tlb_vp_m[fifo_q] <= vpid_q;
      tlb_pg_m[fifo_q] <= addr_q[AW-1:12];
      tlb_hf_m[fifo_q] <= hpa[AW-1:12];
    end
    if (state_q == SGuest && rd_vld_q && match) begin
      gpa_q   <= g_r[2*AW-1:AW] | {{(AW-12){1'b0}}, addr_q[11:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; idx_q <= '0; rd_vld_q <= 1'b0; rd_idx_q <= '0;
      gcnt_q <= '0; ecnt_q <= '0; fifo_q <= '0;
      hit_q <= '0; miss_q <= '0; acc_q <= '0;
      st_q <= '0; cost_q <= '0; host_q <= '0; ovld_q <= 1'b0;
      tlb_v_q <= '0; g_pres_q <= '0; e_pres_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == ntst_pkg::CfgGuestCount) gcnt_q <= cfg_data_i;
        else                                        ecnt_q <= cfg_data_i;
      end
      rd_idx_q <= idx_q;
      rd_vld_q <= 1'b0;
      case (state_q)
        SIdle: if (in_acc) begin
          idx_q <= '0;
          case (s_axis_tdata[1:0])
            ntst_pkg::CmdTranslate: begin
              state_q <= STlb; rd_vld_q <= 1'b1; idx_q <= (XW+1)'(1);
            end
            ntst_pkg::CmdWrGuest: begin
              g_pres_q[s_axis_tdata[119:114]] <= s_axis_tdata[121];
              state_q <= SOut;
            end
            ntst_pkg::CmdWrEpt: begin
              e_pres_q[s_axis_tdata[119:114]] <= s_axis_tdata[121];
              state_q <= SOut;
            end
            default: state_q <= SOut;
          endcase
          st_q <= ntst_pkg::StWrDone; host_q <= '0; cost_q <= '0;
        end
        STlb: begin
          if (match) begin
            hit_q <= hit_q + 32'd1; st_q <= ntst_pkg::StHit;
            host_q <= {thf_r, addr_q[11:0]}; state_q <= SOut;
          end else if (rd_idx_q == (XW+1)'(ntst_pkg::TlbEntries - 1)) begin
            miss_q <= miss_q + 32'd1; idx_q <= '0; state_q <= SGuest;
          end else begin
            idx_q <= idx_q + 1'b1; rd_vld_q <= 1'b1;
          end
        end
        SGuest: begin
          if (rd_vld_q && match) begin
            cost_q <= g_r[2*AW] ? ntst_pkg::CostHuge : ntst_pkg::CostSmall;
            acc_q  <= acc_q + 32'(g_r[2*AW] ? ntst_pkg::CostHuge : ntst_pkg::CostSmall);
            idx_q <= '0; state_q <= SEpt;
          end else if (idx_q >= gn) begin
            st_q <= ntst_pkg::StGFault; state_q <= SOut;
          end else begin
            idx_q <= idx_q + 1'b1; rd_vld_q <= 1'b1;
          end
        end
        SEpt: begin
          if (rd_vld_q && match) begin
            st_q <= ntst_pkg::StWalkOk; host_q <= hpa;
            tlb_v_q[fifo_q] <= 1'b1; fifo_q <= fifo_q + 1'b1; state_q <= SOut;
          end else if (idx_q >= en) begin
            st_q <= ntst_pkg::StEptViol; state_q <= SOut;
          end else begin
            idx_q <= idx_q + 1'b1; rd_vld_q <= 1'b1;
          end
        end
        SOut: begin
          if (!ovld_q) ovld_q <= 1'b1;
          else if (m_axis_tready) begin
            // TLB scan of the next item starts reading at slot zero
            ovld_q <= 1'b0; idx_q <= '0; state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // a result is shown only in the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovld_q |-> state_q == SOut)
    else $error("result valid outside output state");
  // the hit counter moves by one at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q != $past(hit_q) |-> hit_q == $past(hit_q) + 32'd1)
    else $error("hit counter jump");
  // no input accepted while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> !s_axis_tready)
    else $error("ready while busy");
endmodule
